FILE: rtl/core/mps_pkg.sv
// Shared types and constants of the mirror partner search block.
package mps_pkg;

  localparam int COORD_W = 16;
  localparam int SQ_W    = 2 * COORD_W + 1;
  localparam int DIST_W  = SQ_W + 1;
  localparam int OUT_IDX_W = 4;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [SQ_W-1:0]   sq_t;

  // One stored point: x in the low half, y in the high half.
  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  // Tag that travels with each candidate through the distance pipeline.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } ctl_t;

endpackage

FILE: rtl/core/mps_point_mem.sv
// Point store: one write port, one registered read port.
module mps_point_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  mps_pkg::point_t wdata,
  input  logic [AW-1:0]   raddr,
  output mps_pkg::point_t rdata
);
  import mps_pkg::*;

  point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/mps_dist_unit.sv
// Shared distance unit: squares of the mirrored offsets, then their sum.
module mps_dist_unit (
  input  logic            clk,
  input  logic            rst,
  input  mps_pkg::point_t pi,
  input  mps_pkg::point_t pj,
  input  mps_pkg::ctl_t   ctl_in,
  output mps_pkg::dist_t  sum_sq,
  output mps_pkg::ctl_t   ctl_out
);
  import mps_pkg::*;

  logic signed [COORD_W:0]     dx;
  logic signed [COORD_W:0]     dy;
  logic signed [2*COORD_W+1:0] dx_sq;
  logic signed [2*COORD_W+1:0] dy_sq;
  sq_t  sq_x;
  sq_t  sq_y;
  ctl_t ctl_sq;

  // Mirroring across the vertical axis turns the x difference into a sum.
  assign dx = {pi.x[COORD_W-1], pi.x} + {pj.x[COORD_W-1], pj.x};
  assign dy = {pi.y[COORD_W-1], pi.y} - {pj.y[COORD_W-1], pj.y};
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_sq  <= '0;
      ctl_out <= '0;
    end else begin
      ctl_sq  <= ctl_in;
      ctl_out <= ctl_sq;
    end
    sq_x   <= dx_sq[SQ_W-1:0];
    sq_y   <= dy_sq[SQ_W-1:0];
    sum_sq <= {1'b0, sq_x} + {1'b0, sq_y};
  end

endmodule

FILE: rtl/core/mirror_partner_search.sv
// Top level of the mirror partner search block.
// Points stream in on s_axis one transfer a cycle; the transfer with tlast closes the set
// and starts the search, and points beyond MAX_POINTS are dropped. For each stored point i
// the sequencer reads i from the point store, then streams all N stored points through one
// shared distance unit (two squarers and an adder, one candidate a cycle) and keeps the
// first minimum of (xi+xj)^2+(yi-yj)^2. The next point waits out any output stall, and
// s_axis is not ready during the search. One result per point leaves on m_axis in load
// order, the last with tlast; the next set may begin loading while that last result still
// waits to be taken.
module mirror_partner_search #(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] point_x, [31:16] point_y
  input  logic        s_axis_tlast,   // set_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [3:0] point_index, [7:4] partner_index
  output logic        m_axis_tlast    // final_result
);
  import mps_pkg::*;

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    ST_LOAD, ST_FETCH, ST_LATCH, ST_SCAN, ST_DRAIN, ST_RESULT
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   idx_i;
  logic [IDX_W-1:0]   idx_j;
  logic [IDX_W-1:0]   cand;
  logic [IDX_W-1:0]   best_j;
  dist_t              best;
  point_t             pi;
  point_t             rdata;
  ctl_t               req_ctl;
  ctl_t               dist_ctl;
  dist_t              cand_dist;
  logic [IDX_W-1:0]   raddr;
  logic               in_xfer;
  logic               store_we;
  logic               last_j;
  logic               last_i;
  logic [IDX_W-1:0]   cand_next;
  logic               take_best;
  logic [IDX_W+OUT_IDX_W-1:0] ext_i;
  logic [IDX_W+OUT_IDX_W-1:0] ext_j;

  assign s_axis_tready = (state == ST_LOAD);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign store_we = in_xfer && (count < CNT_W'(MAX_POINTS));
  assign raddr    = (state == ST_SCAN) ? idx_j : idx_i;
  assign last_j   = (CNT_W'(idx_j) + CNT_W'(1)) == count;
  assign last_i   = (CNT_W'(idx_i) + CNT_W'(1)) == count;
  assign cand_next = dist_ctl.first ? '0 : cand + IDX_W'(1);
  assign take_best = dist_ctl.first || (cand_dist < best);
  assign ext_i = {{OUT_IDX_W{1'b0}}, idx_i};
  assign ext_j = {{OUT_IDX_W{1'b0}}, best_j};

  mps_point_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (point_t'(s_axis_tdata)),
    .raddr (raddr),
    .rdata (rdata)
  );

  mps_dist_unit u_dist (
    .clk     (clk),
    .rst     (rst),
    .pi      (pi),
    .pj      (rdata),
    .ctl_in  (req_ctl),
    .sum_sq  (cand_dist),
    .ctl_out (dist_ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      count         <= '0;
      idx_i         <= '0;
      idx_j         <= '0;
      req_ctl       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state != ST_SCAN) begin
        req_ctl <= '0;
      end
      // In the result state the valid flag is set again whenever the slot is free.
      if (m_axis_tvalid && m_axis_tready && (state != ST_RESULT)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            if (store_we) begin
              count <= count + CNT_W'(1);
            end
            if (s_axis_tlast) begin
              idx_i <= '0;
              state <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_LATCH;
        end
        ST_LATCH: begin
          idx_j <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          req_ctl <= '{vld: 1'b1, first: (idx_j == '0), last: last_j};
          idx_j   <= idx_j + IDX_W'(1);
          if (last_j) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (dist_ctl.vld && dist_ctl.last) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {ext_j[OUT_IDX_W-1:0], ext_i[OUT_IDX_W-1:0]};
            m_axis_tlast  <= last_i;
            if (last_i) begin
              count <= '0;
              state <= ST_LOAD;
            end else begin
              idx_i <= idx_i + IDX_W'(1);
              state <= ST_FETCH;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
    if (state == ST_LATCH) begin
      pi <= rdata;
    end
    if (dist_ctl.vld) begin
      cand <= cand_next;
      if (take_best) begin
        best   <= cand_dist;
        best_j <= cand_next;
      end
    end
  end

endmodule

FILE: rtl/core/mps_checker.sv
// Port-level checks of the mirror partner search block and their bind.
module mps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // While points are being loaded, only the final result of the last set may wait.
  a_load_only_final: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("non-final result pending while loading");

  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still ready after the set closed");

endmodule

bind mirror_partner_search mps_checker u_mps_checker (.*);
